### hw/rtl/jsc_pkg.sv
// Shared types, codes and constants for the Jacobi symbol v(1) checker.
// Used by every module of the block except jsc_ram; depends on nothing.
package jsc_pkg;

	localparam int unsigned STORE_DEPTH = 4096;
	localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
	localparam int unsigned CMP_W       = 18;
	localparam int unsigned CNT_W       = 48;
	localparam int unsigned NUM_CNT     = 7;
	localparam int unsigned SEL_W       = 3;
	localparam int unsigned IDX_W       = 12;
	localparam int unsigned CHAR_W      = 8;
	localparam int unsigned LEN_W       = 13;
	localparam int unsigned MIN_W       = 12;
	localparam int unsigned CFG_DATA_W  = 13;
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned RAM_W       = CHAR_W + 1;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [LEN_W-1:0] LINE_LENGTH_RST   = 13'd4096;
	localparam logic [MIN_W-1:0] MIN_CANDIDATE_RST = 12'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_CANDIDATE = 1'd1;

	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_LOOKUP = 2'd1;
	localparam logic [1:0] KIND_CHECK  = 2'd2;
	localparam logic [1:0] KIND_READ   = 2'd3;

	localparam logic [1:0] SYM_MINUS   = 2'd0;
	localparam logic [1:0] SYM_ZERO    = 2'd1;
	localparam logic [1:0] SYM_PLUS    = 2'd2;
	localparam logic [1:0] SYM_INVALID = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_BELOW = 2'd2;

	localparam int unsigned CNT_OPS     = 0;
	localparam int unsigned CNT_MISS    = 1;
	localparam int unsigned CNT_HIT     = 2;
	localparam int unsigned CNT_LOAD    = 3;
	localparam int unsigned CNT_RANGE   = 4;
	localparam int unsigned CNT_INVALID = 5;
	localparam int unsigned CNT_V1      = 6;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

	typedef struct packed {
		logic [1:0]        kind;
		logic [IDX_W-1:0]  index;
		logic [CHAR_W-1:0] character;
		logic [SEL_W-1:0]  counter_select;
	} in_word_t;

	typedef struct packed {
		logic [1:0]       symbol;
		logic             v1_valid;
		logic [1:0]       status;
		logic [CNT_W-1:0] counter_value;
	} out_word_t;

	typedef enum logic [2:0] {
		OP_LOAD,
		OP_LOOKUP,
		OP_CHECK,
		OP_READ,
		OP_BELOW
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] addr_a;
		logic              a_oor;
		logic [ADDR_W-1:0] addr_b;
		logic              b_oor;
		logic [CHAR_W-1:0] character;
		logic [SEL_W-1:0]  counter_select;
	} cmd_t;

	function automatic logic [1:0] decode_char(input logic [CHAR_W-1:0] c);
		logic [1:0] s;
		case (c)
			CHAR_MINUS: s = SYM_MINUS;
			CHAR_ZERO:  s = SYM_ZERO;
			CHAR_PLUS:  s = SYM_PLUS;
			default:    s = SYM_INVALID;
		endcase
		return s;
	endfunction

endpackage

### hw/rtl/jacobi_symbol_v1_checker_unit.sv
// Jacobi symbol v(1) checker, top level.
// Output path: read, below-minimum and first-address out-of-range words go from the queue
// head into the single output register; a lookup first passes one registered store read,
// a v(1) check one or two (second store read). Loads give no output word. Throughput:
// one load per cycle while the back end idles; others also wait for out_valid low.
// Async reset clears control and counters; config returns to 4096 and 3; loads clear marks.
module jacobi_symbol_v1_checker_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [jsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jsc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  jsc_pkg::in_word_t              in_word,
	output logic                           out_valid,
	input  logic                           out_ready,
	output jsc_pkg::out_word_t             out_word
);

	logic          q_full;
	logic          push;
	jsc_pkg::cmd_t push_cmd;
	logic          head_valid;
	jsc_pkg::cmd_t head;
	logic          pop;

	jsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	jsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop)
	);

	jsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

### hw/rtl/jsc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package dependency.
module jsc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/jsc_front.sv
// Front end: configuration registers, input acceptance and classification.
// Turns each input word into a command with resolved addresses and range flags.
// Depends on jsc_pkg.
module jsc_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [jsc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [jsc_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  jsc_pkg::in_word_t                    in_word,
	input  logic                                 q_full,
	output logic                                 push,
	output jsc_pkg::cmd_t                        push_cmd
);

	logic [jsc_pkg::LEN_W-1:0] line_length_q;
	logic [jsc_pkg::MIN_W-1:0] min_candidate_q;

	logic [jsc_pkg::CMP_W-1:0] limit;
	logic [jsc_pkg::CMP_W-1:0] idx_w;
	logic [jsc_pkg::CMP_W-1:0] pos_a;
	logic [jsc_pkg::CMP_W-1:0] pos_b;
	logic                      in_store;
	logic                      low_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q   <= jsc_pkg::LINE_LENGTH_RST;
			min_candidate_q <= jsc_pkg::MIN_CANDIDATE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				jsc_pkg::CFG_LINE_LENGTH:   line_length_q <= cfg_data[jsc_pkg::LEN_W-1:0];
				jsc_pkg::CFG_MIN_CANDIDATE: min_candidate_q <= cfg_data[jsc_pkg::MIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (jsc_pkg::CMP_W'(line_length_q) < jsc_pkg::CMP_W'(jsc_pkg::STORE_DEPTH)) begin
			limit = jsc_pkg::CMP_W'(line_length_q);
		end else begin
			limit = jsc_pkg::CMP_W'(jsc_pkg::STORE_DEPTH);
		end
		idx_w    = jsc_pkg::CMP_W'(in_word.index);
		in_store = idx_w < jsc_pkg::CMP_W'(jsc_pkg::STORE_DEPTH);
		low_x    = idx_w < jsc_pkg::CMP_W'(2);
		pos_a    = idx_w;
		pos_b    = idx_w + jsc_pkg::CMP_W'(2);

		push_cmd                = '0;
		push_cmd.character      = in_word.character;
		push_cmd.counter_select = in_word.counter_select;
		case (in_word.kind)
			jsc_pkg::KIND_LOAD: begin
				push_cmd.op = jsc_pkg::OP_LOAD;
			end
			jsc_pkg::KIND_LOOKUP: begin
				push_cmd.op    = jsc_pkg::OP_LOOKUP;
				push_cmd.a_oor = pos_a >= limit;
			end
			jsc_pkg::KIND_CHECK: begin
				pos_a = idx_w - jsc_pkg::CMP_W'(2);
				if (in_word.index < min_candidate_q) begin
					push_cmd.op = jsc_pkg::OP_BELOW;
				end else begin
					push_cmd.op = jsc_pkg::OP_CHECK;
				end
				push_cmd.a_oor = low_x || (pos_a >= limit);
				push_cmd.b_oor = pos_b >= limit;
			end
			default: begin
				push_cmd.op = jsc_pkg::OP_READ;
			end
		endcase
		push_cmd.addr_a = pos_a[jsc_pkg::ADDR_W-1:0];
		push_cmd.addr_b = pos_b[jsc_pkg::ADDR_W-1:0];
	end

	assign in_ready = !q_full;
	// loads outside the store are accepted and dropped
	assign push = in_valid && !q_full && (in_store || (in_word.kind != jsc_pkg::KIND_LOAD));

endmodule

### hw/rtl/jsc_queue.sv
// Short command queue between front and back end.
// Depends on jsc_pkg for the command type and depth.
module jsc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jsc_pkg::cmd_t push_cmd,
	output logic          full,
	output logic          head_valid,
	output jsc_pkg::cmd_t head,
	input  logic          pop
);

	localparam int unsigned PTR_W = (jsc_pkg::QUEUE_DEPTH > 1) ? $clog2(jsc_pkg::QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(jsc_pkg::QUEUE_DEPTH + 1);

	jsc_pkg::cmd_t    slot_q [jsc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = count_q == CNT_W'(jsc_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				if (wr_ptr_q == PTR_W'(jsc_pkg::QUEUE_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + PTR_W'(1);
				end
			end
			if (do_pop) begin
				if (rd_ptr_q == PTR_W'(jsc_pkg::QUEUE_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + PTR_W'(1);
				end
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### hw/rtl/jsc_back.sv
// Back end: executes commands against the symbol store, keeps statistics
// and holds the output word. Depends on jsc_pkg and jsc_ram.
module jsc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  jsc_pkg::cmd_t      head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output jsc_pkg::out_word_t out_word
);

	typedef enum logic [1:0] {
		B_IDLE,
		B_RD_A,
		B_RD_B
	} state_t;

	state_t             state_q;
	jsc_pkg::cmd_t      cmd_q;
	logic               out_valid_q;
	jsc_pkg::out_word_t out_q;
	logic               out_set;
	jsc_pkg::out_word_t out_d;

	logic [jsc_pkg::CNT_W-1:0] cnt_q [jsc_pkg::NUM_CNT];
	logic [1:0]                inc [jsc_pkg::NUM_CNT];

	logic                       ram_we;
	logic [jsc_pkg::ADDR_W-1:0] ram_waddr;
	logic [jsc_pkg::RAM_W-1:0]  ram_wdata;
	logic                       ram_re;
	logic [jsc_pkg::ADDR_W-1:0] ram_raddr;
	logic [jsc_pkg::RAM_W-1:0]  ram_rdata;

	logic       marked;
	logic [1:0] dec_sym;
	logic       plus_check;

	// store word: {decoded mark, raw character}
	jsc_ram #(
		.WIDTH(jsc_pkg::RAM_W),
		.DEPTH(jsc_pkg::STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign marked     = ram_rdata[jsc_pkg::CHAR_W];
	assign dec_sym    = jsc_pkg::decode_char(ram_rdata[jsc_pkg::CHAR_W-1:0]);
	assign plus_check = (cmd_q.op == jsc_pkg::OP_CHECK) && (dec_sym == jsc_pkg::SYM_PLUS);

	always_comb begin
		pop       = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = head.addr_a;
		ram_wdata = {1'b0, head.character};
		ram_re    = 1'b0;
		ram_raddr = head.addr_a;
		for (int i = 0; i < jsc_pkg::NUM_CNT; i++) begin
			inc[i] = 2'd0;
		end
		case (state_q)
			B_IDLE: begin
				if (head_valid && ((head.op == jsc_pkg::OP_LOAD) || !out_valid_q)) begin
					pop = 1'b1;
					case (head.op)
						jsc_pkg::OP_LOAD: begin
							ram_we = 1'b1;
						end
						jsc_pkg::OP_LOOKUP, jsc_pkg::OP_CHECK: begin
							if (head.a_oor) begin
								inc[jsc_pkg::CNT_OPS]   = 2'd1;
								inc[jsc_pkg::CNT_RANGE] = 2'd1;
							end else begin
								ram_re = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			B_RD_A, B_RD_B: begin
				inc[jsc_pkg::CNT_OPS] = 2'd1;
				ram_waddr = (state_q == B_RD_B) ? cmd_q.addr_b : cmd_q.addr_a;
				ram_wdata = {1'b1, ram_rdata[jsc_pkg::CHAR_W-1:0]};
				if (marked) begin
					inc[jsc_pkg::CNT_HIT] = 2'd1;
				end else begin
					inc[jsc_pkg::CNT_MISS] = 2'd1;
					if (dec_sym != jsc_pkg::SYM_INVALID) begin
						ram_we                 = 1'b1;
						inc[jsc_pkg::CNT_LOAD] = 2'd1;
					end else begin
						inc[jsc_pkg::CNT_INVALID] = 2'd1;
					end
				end
				if (state_q == B_RD_A && plus_check) begin
					if (cmd_q.b_oor) begin
						inc[jsc_pkg::CNT_OPS]   = 2'd2;
						inc[jsc_pkg::CNT_RANGE] = 2'd1;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = cmd_q.addr_b;
					end
				end
				if (state_q == B_RD_B && dec_sym == jsc_pkg::SYM_MINUS) begin
					inc[jsc_pkg::CNT_V1] = 2'd1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		out_set = 1'b0;
		out_d   = '0;
		case (state_q)
			B_IDLE: begin
				if (pop) begin
					case (head.op)
						jsc_pkg::OP_READ: begin
							out_set = 1'b1;
							if (head.counter_select < jsc_pkg::SEL_W'(jsc_pkg::NUM_CNT)) begin
								out_d.counter_value = cnt_q[head.counter_select];
							end else begin
								out_d.status = jsc_pkg::ST_RANGE;
							end
						end
						jsc_pkg::OP_BELOW: begin
							out_set      = 1'b1;
							out_d.symbol = jsc_pkg::SYM_INVALID;
							out_d.status = jsc_pkg::ST_BELOW;
						end
						jsc_pkg::OP_LOOKUP, jsc_pkg::OP_CHECK: begin
							if (head.a_oor) begin
								out_set      = 1'b1;
								out_d.symbol = jsc_pkg::SYM_INVALID;
								out_d.status = jsc_pkg::ST_RANGE;
							end
						end
						default: ;
					endcase
				end
			end
			B_RD_A: begin
				if (!(plus_check && !cmd_q.b_oor)) begin
					out_set = 1'b1;
					if (plus_check) begin
						out_d.symbol = jsc_pkg::SYM_INVALID;
						out_d.status = jsc_pkg::ST_RANGE;
					end else begin
						out_d.symbol = dec_sym;
					end
				end
			end
			B_RD_B: begin
				out_set        = 1'b1;
				out_d.symbol   = dec_sym;
				out_d.v1_valid = dec_sym == jsc_pkg::SYM_MINUS;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < jsc_pkg::NUM_CNT; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < jsc_pkg::NUM_CNT; i++) begin
				cnt_q[i] <= cnt_q[i] + jsc_pkg::CNT_W'(inc[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cmd_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			out_valid_q <= out_set || (out_valid_q && !out_ready);
			if (out_set) begin
				out_q <= out_d;
			end
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						cmd_q <= head;
						if ((head.op inside {jsc_pkg::OP_LOOKUP, jsc_pkg::OP_CHECK}) &&
								!head.a_oor) begin
							state_q <= B_RD_A;
						end
					end
				end
				B_RD_A: begin
					if (plus_check && !cmd_q.b_oor) begin
						state_q <= B_RD_B;
					end else begin
						state_q <= B_IDLE;
					end
				end
				B_RD_B: begin
					state_q <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

### hw/rtl/jsc_checker.sv
// Port-level assertions for the Jacobi symbol v(1) checker, and their bind.
// Depends on jsc_pkg and the top level jacobi_symbol_v1_checker_unit.
module jsc_port_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_write,
	input logic [jsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [jsc_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic                           in_valid,
	input logic                           in_ready,
	input jsc_pkg::in_word_t              in_word,
	input logic                           out_valid,
	input logic                           out_ready,
	input jsc_pkg::out_word_t             out_word
);

	// output word holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	a_v1_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.v1_valid |->
			out_word.symbol == jsc_pkg::SYM_MINUS && out_word.status == jsc_pkg::ST_OK &&
			out_word.counter_value == '0)
		else $error("v1 hit with inconsistent fields");

	a_below_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status == jsc_pkg::ST_BELOW |->
			out_word.symbol == jsc_pkg::SYM_INVALID && !out_word.v1_valid &&
			out_word.counter_value == '0)
		else $error("below-minimum word with inconsistent fields");

	a_range_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status == jsc_pkg::ST_RANGE |->
			!out_word.v1_valid && out_word.counter_value == '0)
		else $error("out-of-range word with inconsistent fields");

endmodule

bind jacobi_symbol_v1_checker_unit jsc_port_checker u_jsc_checker (.*);

### sim/jsc_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the Jacobi symbol v(1) checker: tracks the config port, predicts each
// result word from the accepted input words and compares it. Depends on jsc_pkg.
module jsc_checker
	import jsc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_word_t              in_word,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_word_t             out_word,
	output int                    failures,
	output int                    outstanding
);

	logic [CHAR_W-1:0] line_chars [STORE_DEPTH];
	bit                decoded    [STORE_DEPTH];
	logic [CNT_W-1:0]  stats      [NUM_CNT];
	logic [LEN_W-1:0]  cur_len;
	logic [MIN_W-1:0]  cur_min;
	out_word_t         result_q [$];
	out_word_t         want;
	int                fail_cnt = 0;

	function automatic logic [1:0] symbol_of(input logic [CHAR_W-1:0] c);
		if (c == CHAR_MINUS) return SYM_MINUS;
		if (c == CHAR_ZERO) return SYM_ZERO;
		if (c == CHAR_PLUS) return SYM_PLUS;
		return SYM_INVALID;
	endfunction

	function automatic void bump(input logic [SEL_W-1:0] which);
		stats[which] = stats[which] + CNT_W'(1);
	endfunction

	function automatic logic [1:0] probe_entry(input logic [LEN_W-1:0] pos,
			input bit below_zero, inout bit oor);
		logic [LEN_W-1:0] limit;
		logic [1:0]       s;
		limit = (cur_len < LEN_W'(STORE_DEPTH)) ? cur_len : LEN_W'(STORE_DEPTH);
		bump(SEL_W'(CNT_OPS));
		if (below_zero || pos >= limit) begin
			bump(SEL_W'(CNT_RANGE));
			oor = 1'b1;
			return SYM_INVALID;
		end
		s = symbol_of(line_chars[pos[ADDR_W-1:0]]);
		if (decoded[pos[ADDR_W-1:0]]) begin
			bump(SEL_W'(CNT_HIT));
			return s;
		end
		bump(SEL_W'(CNT_MISS));
		if (s != SYM_INVALID) begin
			decoded[pos[ADDR_W-1:0]] = 1'b1;
			bump(SEL_W'(CNT_LOAD));
		end else begin
			bump(SEL_W'(CNT_INVALID));
		end
		return s;
	endfunction

	function automatic void predict_word(input in_word_t w);
		out_word_t e;
		bit        oor;
		logic [1:0] s;
		e = '0;
		oor = 1'b0;
		case (w.kind)
			KIND_LOAD: begin
				line_chars[w.index] = w.character;
				decoded[w.index] = 1'b0;
			end
			KIND_LOOKUP: begin
				e.symbol = probe_entry({1'b0, w.index}, 1'b0, oor);
				e.status = oor ? ST_RANGE : ST_OK;
				result_q.push_back(e);
			end
			KIND_CHECK: begin
				if (w.index < cur_min) begin
					e.symbol = SYM_INVALID;
					e.status = ST_BELOW;
				end else begin
					s = probe_entry({1'b0, w.index} - 13'd2, w.index < IDX_W'(2), oor);
					if (s == SYM_PLUS) begin
						s = probe_entry({1'b0, w.index} + 13'd2, 1'b0, oor);
						if (s == SYM_MINUS) begin
							bump(SEL_W'(CNT_V1));
							e.v1_valid = 1'b1;
						end
					end
					e.symbol = s;
					e.status = oor ? ST_RANGE : ST_OK;
				end
				result_q.push_back(e);
			end
			default: begin
				if (w.counter_select < SEL_W'(NUM_CNT))
					e.counter_value = stats[w.counter_select];
				else
					e.status = ST_RANGE;
				result_q.push_back(e);
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++) begin
				line_chars[i] = '0;
				decoded[i] = 1'b0;
			end
			for (int i = 0; i < NUM_CNT; i++)
				stats[i] = '0;
			cur_len = LINE_LENGTH_RST;
			cur_min = MIN_CANDIDATE_RST;
			result_q.delete();
			outstanding <= 0;
			failures <= fail_cnt;
		end else begin
			if (cfg_write) begin
				if (cfg_index == CFG_LINE_LENGTH)
					cur_len = cfg_data[LEN_W-1:0];
				else
					cur_min = cfg_data[MIN_W-1:0];
			end
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					$error("result word with nothing expected: %p", out_word);
					fail_cnt++;
				end else begin
					want = result_q.pop_front();
					if (out_word.symbol !== want.symbol) begin
						$error("symbol: expected %0d, actual %0d", want.symbol, out_word.symbol);
						fail_cnt++;
					end
					if (out_word.v1_valid !== want.v1_valid) begin
						$error("v1_valid: expected %0d, actual %0d", want.v1_valid,
							out_word.v1_valid);
						fail_cnt++;
					end
					if (out_word.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, out_word.status);
						fail_cnt++;
					end
					if (out_word.counter_value !== want.counter_value) begin
						$error("counter_value: expected %0d, actual %0d", want.counter_value,
							out_word.counter_value);
						fail_cnt++;
					end
				end
			end
			if (in_valid && in_ready)
				predict_word(in_word);
			outstanding <= result_q.size();
			failures <= fail_cnt;
		end
	end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// Top of the Jacobi symbol v(1) checker test: clock, reset, config phases and word
// stimulus with random idling; checking is done by jsc_checker. Depends on jsc_pkg.
module testbench;
	import jsc_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	in_word_t              in_word;
	logic                  out_valid;
	logic                  out_ready;
	out_word_t             out_word;
	int                    failures;
	int                    outstanding;

	bit calm;
	bit hold_req;
	bit written [STORE_DEPTH];
	int cur_len;

	int phase_len [8] = '{4096, 1, 0, 8191, 40, 4096, 20, 4095};
	int phase_min [8] = '{3, 2, 4095, 0, 1, 4095, 2, 2};

	jacobi_symbol_v1_checker_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	jsc_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_word     (in_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_word    (out_word),
		.failures    (failures),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#(64'd20_000_000);
		$display("jacobi_symbol_v1_checker_unit test failed");
		$finish;
	end

	function automatic in_word_t make_word(input logic [1:0] kind, input int idx,
			input int ch, input int sel);
		in_word_t w;
		w.kind = kind;
		w.index = IDX_W'(idx);
		w.character = CHAR_W'(ch);
		w.counter_select = SEL_W'(sel);
		return w;
	endfunction

	function automatic int pick_char();
		case ($urandom_range(0, 19))
			0, 1, 2: return $urandom_range(0, 255);
			3, 4, 5, 6, 7: return int'(CHAR_MINUS);
			8, 9, 10, 11, 12: return int'(CHAR_ZERO);
			default: return int'(CHAR_PLUS);
		endcase
	endfunction

	function automatic int pick_index();
		int ll;
		case ($urandom_range(0, 9))
			0, 1: return $urandom_range(0, 4095);
			2: begin
				ll = (cur_len > 4096) ? 4096 : cur_len;
				ll = ll - 1 + int'($urandom_range(0, 2));
				if (ll < 0) ll = 0;
				if (ll > 4095) ll = 4095;
				return ll;
			end
			3: return $urandom_range(4088, 4095);
			default: return $urandom_range(0, 31);
		endcase
	endfunction

	task automatic send_word(input in_word_t w);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic load_entry(input int i, input int ch);
		send_word(make_word(KIND_LOAD, i, ch, $urandom));
		written[IDX_W'(i)] = 1'b1;
	endtask

	// never let a lookup touch an entry that holds nothing yet
	task automatic make_ready(input int i);
		if (!written[IDX_W'(i)]) load_entry(i, pick_char());
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_config(input int len, input int minc);
		cfg_write <= 1'b1;
		cfg_index <= CFG_LINE_LENGTH;
		cfg_data <= CFG_DATA_W'(len);
		@(posedge clk);
		cfg_index <= CFG_MIN_CANDIDATE;
		cfg_data <= CFG_DATA_W'(minc);
		@(posedge clk);
		cfg_write <= 1'b0;
		cur_len = len;
	endtask

	task automatic random_op();
		int x;
		int r;
		r = $urandom_range(0, 99);
		x = pick_index();
		if (r < 30) begin
			load_entry(x, pick_char());
		end else if (r < 60) begin
			make_ready(x);
			send_word(make_word(KIND_LOOKUP, x, $urandom, $urandom));
		end else if (r < 90) begin
			// plant a +1 / -1 pair around x now and then
			if ($urandom_range(0, 2) == 0) begin
				if (x >= 2) load_entry(x - 2, int'(CHAR_PLUS));
				if (x + 2 < STORE_DEPTH)
					load_entry(x + 2, $urandom_range(0, 1) ? int'(CHAR_MINUS) : pick_char());
			end
			if (x >= 2) make_ready(x - 2);
			if (x + 2 < STORE_DEPTH) make_ready(x + 2);
			send_word(make_word(KIND_CHECK, x, $urandom, $urandom));
		end else begin
			send_word(make_word(KIND_READ, $urandom, $urandom, $urandom));
		end
	endtask

	initial begin
		bit held;
		held = 1'b0;
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_word = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		cur_len = 4096;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_config(4096, 3);

		load_entry(0, int'(CHAR_ZERO));
		load_entry(1, int'(CHAR_PLUS));
		load_entry(2, 255);
		load_entry(3, 0);
		load_entry(4, int'(CHAR_MINUS));
		load_entry(5, int'(CHAR_MINUS));
		load_entry(4093, int'(CHAR_PLUS));
		load_entry(4095, int'(CHAR_MINUS));
		send_word(make_word(KIND_LOOKUP, 0, 0, 0));
		send_word(make_word(KIND_LOOKUP, 0, 255, 7));
		send_word(make_word(KIND_LOOKUP, 2, 0, 0));
		send_word(make_word(KIND_LOOKUP, 2, 0, 0));
		send_word(make_word(KIND_LOOKUP, 4095, 0, 0));
		send_word(make_word(KIND_CHECK, 3, 0, 0));
		send_word(make_word(KIND_CHECK, 4095, 0, 0));
		send_word(make_word(KIND_CHECK, 6, 0, 0));
		send_word(make_word(KIND_CHECK, 4, 0, 0));
		send_word(make_word(KIND_CHECK, 2, 0, 0));
		for (int s = 0; s < 8; s++)
			send_word(make_word(KIND_READ, 4095, 255, s));
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			calm = (p == 7);
			set_config(phase_len[p], phase_min[p]);
			for (int n = 0; n < 90; n++) begin
				if (p == 0 && n == 40) hold_req = 1'b1;
				if (p == 4 && n == 60) wait_drained();
				random_op();
			end
			wait_drained();
		end

		if (failures == 0)
			$display("jacobi_symbol_v1_checker_unit test passed");
		else
			$display("jacobi_symbol_v1_checker_unit test failed");
		$finish;
	end

endmodule
